@@ rtl/core/dsf_pkg.sv @@
// shared constants, codes and types of the depth speckle filter
package dsf_pkg;

  // row memory geometry
  localparam int MAX_WIDTH  = 4096;
  localparam int WIDTH_CAP  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int HEIGHT_CAP = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W      = $clog2(WIDTH_CAP + 1);

  // field and register widths
  localparam int DEPTH_W = 16;
  localparam int CFG_W   = 13;
  localparam int THR_W   = 16;
  localparam int ROW_W   = 12;
  localparam int IDX_W   = 2;
  localparam int CMP_W   = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register indexes
  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

  // operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // reset values of the registers
  localparam logic [CFG_W-1:0] RST_WIDTH     = 13'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT    = 13'd480;
  localparam logic [THR_W-1:0] RST_THRESHOLD = 16'd50;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [THR_W-1:0] threshold;
  } dsf_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  col;
    logic               emit;
    logic               has_up;
    logic               has_down;
    logic               has_left;
    logic               has_right;
    logic               wr_centre;
    logic               frame_end;
    logic [DEPTH_W-1:0] depth;
  } dsf_cmd_t;

endpackage

@@ rtl/core/dsf_front.sv @@
// front end: raster bookkeeping, classifies each transaction into a row command
module dsf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dsf_pkg::dsf_cfg_t         cfg,
  input  logic                      in_valid,
  input  logic                      in_op,
  input  logic [dsf_pkg::DEPTH_W-1:0] in_depth,
  input  logic                      queue_full,
  output logic                      in_ready,
  output logic                      push,
  output dsf_pkg::dsf_cmd_t         push_cmd
);
  import dsf_pkg::*;

  logic [ADDR_W-1:0] column_r, column_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  pending_r, pending_nxt;

  logic [CFG_W-1:0]  w_eff, h_eff;
  logic [CMP_W-1:0]  w_ext;
  logic [ADDR_W-1:0] pix_col, drn_col;
  logic [CMP_W-1:0]  pix_col_p1, drn_col_p1;
  logic [CNT_W-1:0]  drn_left;
  logic              last_col, last_row, in_fire;

  assign in_ready = !queue_full;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    // effective frame size
    if (cfg.width == '0) begin
      w_eff = CFG_W'(1);
    end else if (cfg.width > CFG_W'(WIDTH_CAP)) begin
      w_eff = CFG_W'(WIDTH_CAP);
    end else begin
      w_eff = cfg.width;
    end
    if (cfg.height == '0) begin
      h_eff = CFG_W'(1);
    end else if (cfg.height > CFG_W'(HEIGHT_CAP)) begin
      h_eff = CFG_W'(HEIGHT_CAP);
    end else begin
      h_eff = cfg.height;
    end
    w_ext = CMP_W'(w_eff);

    // pixel path: stale column restarts at zero
    pix_col    = (CMP_W'(column_r) >= w_ext) ? '0 : column_r;
    pix_col_p1 = CMP_W'(pix_col) + CMP_W'(1);
    last_col   = pix_col_p1 >= w_ext;
    last_row   = (CFG_W'(row_r) + CFG_W'(1)) >= h_eff;

    // drain path: pending count saturates to the width
    drn_left   = (CMP_W'(pending_r) > w_ext) ? CNT_W'(w_eff) : pending_r;
    drn_col    = ADDR_W'(w_ext - CMP_W'(drn_left));
    drn_col_p1 = CMP_W'(drn_col) + CMP_W'(1);

    column_nxt = column_r;
    row_nxt    = row_r;
    pending_nxt = pending_r;
    push       = 1'b0;
    push_cmd   = '0;
    push_cmd.depth = in_depth;

    unique case (in_op)
      OP_PIXEL: begin
        push_cmd.col       = pix_col;
        push_cmd.emit      = row_r != '0;
        push_cmd.has_up    = row_r > ROW_W'(1);
        push_cmd.has_down  = 1'b1;
        push_cmd.has_left  = pix_col != '0;
        push_cmd.has_right = !last_col;
        push_cmd.wr_centre = 1'b1;
        push_cmd.frame_end = 1'b0;
        if (pending_r == '0) begin
          push = in_fire;
          if (last_col) begin
            column_nxt = '0;
            if (last_row) begin
              row_nxt     = '0;
              pending_nxt = CNT_W'(w_eff);
            end else begin
              row_nxt = row_r + ROW_W'(1);
            end
          end else begin
            column_nxt = ADDR_W'(pix_col_p1);
          end
        end
      end
      OP_DRAIN: begin
        push_cmd.col       = drn_col;
        push_cmd.emit      = 1'b1;
        push_cmd.has_up    = h_eff >= CFG_W'(2);
        push_cmd.has_down  = 1'b0;
        push_cmd.has_left  = drn_col != '0;
        push_cmd.has_right = drn_col_p1 < w_ext;
        push_cmd.wr_centre = 1'b0;
        push_cmd.frame_end = drn_left == CNT_W'(1);
        if (pending_r != '0) begin
          push        = in_fire;
          pending_nxt = drn_left - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r  <= '0;
      row_r     <= '0;
      pending_r <= '0;
    end else if (in_fire) begin
      column_r  <= column_nxt;
      row_r     <= row_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

@@ rtl/core/dsf_cmd_fifo.sv @@
// small command queue between front end and back end
module dsf_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dsf_pkg::dsf_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output dsf_pkg::dsf_cmd_t head_cmd
);
  import dsf_pkg::*;

  dsf_cmd_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    count_r;

  assign full       = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      priority if (push && !pop) begin
        count_r <= count_r + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W + 1)'(1);
      end else begin
        count_r <= count_r;
      end
    end
  end

endmodule

@@ rtl/core/dsf_back.sv @@
// back end: row memories, neighbour test and output register
module dsf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dsf_pkg::THR_W-1:0]   threshold,
  input  logic                        head_valid,
  input  dsf_pkg::dsf_cmd_t           head_cmd,
  output logic                        pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [dsf_pkg::DEPTH_W-1:0] out_depth,
  output logic                        out_last
);
  import dsf_pkg::*;

  logic [DEPTH_W-1:0] above_mem  [MAX_WIDTH];
  logic [DEPTH_W-1:0] centre_mem [MAX_WIDTH];

  dsf_cmd_t           s1_cmd_r;
  logic               s1_valid_r;
  logic [DEPTH_W-1:0] ab_c_r, ab_l_r, ce_c_r, ce_r_r;

  // most recent write of each memory, forwarded over the read latency
  logic               la_v_r, lc_v_r;
  logic [ADDR_W-1:0]  la_addr_r, lc_addr_r;
  logic [DEPTH_W-1:0] la_data_r, lc_data_r;

  logic               out_valid_r, out_last_r;
  logic [DEPTH_W-1:0] out_depth_r;

  logic [ADDR_W-1:0]  addr_l, addr_r;
  logic [DEPTH_W-1:0] up_v, left_v, centre_v, right_v, result_v;
  logic               s1_fire, out_load, kept;

  function automatic logic is_close(input logic [DEPTH_W-1:0] a,
                                    input logic [DEPTH_W-1:0] b,
                                    input logic [THR_W-1:0]   t);
    logic [DEPTH_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d < t;
  endfunction

  assign s1_fire  = s1_valid_r && (!s1_cmd_r.emit || !out_valid_r || out_ready);
  assign pop      = head_valid && (!s1_valid_r || s1_fire);
  assign out_load = s1_fire && s1_cmd_r.emit;
  assign addr_l   = head_cmd.col - ADDR_W'(1);
  assign addr_r   = head_cmd.col + ADDR_W'(1);

  always_comb begin
    up_v     = (la_v_r && la_addr_r == s1_cmd_r.col) ? la_data_r : ab_c_r;
    left_v   = (la_v_r && la_addr_r == s1_cmd_r.col - ADDR_W'(1)) ? la_data_r : ab_l_r;
    centre_v = (lc_v_r && lc_addr_r == s1_cmd_r.col) ? lc_data_r : ce_c_r;
    right_v  = (lc_v_r && lc_addr_r == s1_cmd_r.col + ADDR_W'(1)) ? lc_data_r : ce_r_r;
    kept = (s1_cmd_r.has_up    && is_close(centre_v, up_v, threshold))
        || (s1_cmd_r.has_down  && is_close(centre_v, s1_cmd_r.depth, threshold))
        || (s1_cmd_r.has_left  && is_close(centre_v, left_v, threshold))
        || (s1_cmd_r.has_right && is_close(centre_v, right_v, threshold));
    result_v = kept ? centre_v : '0;
  end

  // memory reads on pop, column shift on fire
  always_ff @(posedge clk) begin
    if (pop) begin
      ab_c_r <= above_mem[head_cmd.col];
      ab_l_r <= above_mem[addr_l];
      ce_c_r <= centre_mem[head_cmd.col];
      ce_r_r <= centre_mem[addr_r];
    end
    if (s1_fire) begin
      above_mem[s1_cmd_r.col] <= centre_v;
      if (s1_cmd_r.wr_centre) begin
        centre_mem[s1_cmd_r.col] <= s1_cmd_r.depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cmd_r <= head_cmd;
    end
    if (s1_fire) begin
      la_addr_r <= s1_cmd_r.col;
      la_data_r <= centre_v;
      if (s1_cmd_r.wr_centre) begin
        lc_addr_r <= s1_cmd_r.col;
        lc_data_r <= s1_cmd_r.depth;
      end
    end
    if (out_load) begin
      out_depth_r <= result_v;
      out_last_r  <= s1_cmd_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      la_v_r      <= 1'b0;
      lc_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        la_v_r <= 1'b1;
        if (s1_cmd_r.wr_centre) begin
          lc_v_r <= 1'b1;
        end
      end
      priority if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_depth = out_depth_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/core/depth_speckle_filter_core.sv @@
// top level of the depth speckle filter: config registers, front end, queue, back end
// path: a result passes the command queue, the stage-1 register and the output register
//   (the emitted pixel is from the row above the incoming one; drain ticks flush the last row)
// throughput: one transaction per cycle while the queue is not full, set by the combinational
//   bookkeeping in the front end and the two read ports of each row memory in the back end
// reset: synchronous, active low; clears counters, queue, pipeline valids and config defaults;
//   row memories are not cleared and hold stale data until rewritten
module depth_speckle_filter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [15:0] depth_in
  input  logic                        in_tuser,   // [0] operation
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [15:0] depth_out
  output logic                        out_tlast,  // frame_end
  // configuration writes
  input  logic                        cfg_wr_en,
  input  logic [dsf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [15:0]                 cfg_wdata
);
  import dsf_pkg::*;

  dsf_cfg_t cfg_r;
  dsf_cmd_t push_cmd, head_cmd;
  logic     queue_full, push, pop, head_valid;

  // register file; the user must write it only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= RST_WIDTH;
      cfg_r.height    <= RST_HEIGHT;
      cfg_r.threshold <= RST_THRESHOLD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_r.width     <= cfg_wdata[CFG_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_r.height    <= cfg_wdata[CFG_W-1:0];
        CFG_THRESHOLD:    cfg_r.threshold <= cfg_wdata[THR_W-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // front end: column, row and drain counters, one command per useful transaction
  dsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_op      (in_tuser),
    .in_depth   (in_tdata[DEPTH_W-1:0]),
    .queue_full (queue_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // decouples input acceptance from output backpressure
  dsf_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back end: row memories with write forwarding, four-neighbour test, output register
  dsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .threshold  (cfg_r.threshold),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_depth  (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

@@ rtl/core/dsf_checker.sv @@
// port-level checks of the depth speckle filter, bound to the top level
module dsf_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // reset empties the command queue, so input is taken at once
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind depth_speckle_filter_core dsf_port_checks u_dsf_checker (.*);

@@ tb/sv/dsf_checker.sv @@
// checker of the depth speckle filter: watches both streams and the register port, predicts and compares
module dsf_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [15:0]               in_tdata,   // [15:0] depth_in
  input  logic                      in_tuser,   // [0] operation
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [15:0]               out_tdata,  // [15:0] depth_out
  input  logic                      out_tlast,  // frame_end
  input  logic                      cfg_wr_en,
  input  logic [dsf_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0]               cfg_wdata,
  input  logic                      closing,
  output int unsigned               fail_count,
  output int unsigned               waiting,
  output int unsigned               result_count,
  output logic                      draining
);
  timeunit 1ns;
  timeprecision 1ps;
  import dsf_pkg::*;

  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               frame_end;
  } filt_px_t;

  filt_px_t owed_px[$];

  // predicted copy of the two row memories and the raster position
  logic [DEPTH_W-1:0] rows_up  [MAX_WIDTH];
  logic [DEPTH_W-1:0] rows_mid [MAX_WIDTH];
  int unsigned        col_pos;
  int unsigned        row_pos;
  int unsigned        drain_left;
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [THR_W-1:0]   thr_reg;
  bit                 closed;

  initial begin
    fail_count   = 0;
    waiting      = 0;
    result_count = 0;
    draining     = 1'b0;
  end

  task automatic flag(input string msg);
    if (fail_count < MAX_PRINTS) $display("[%0t] %s", $realtime, msg);
    fail_count++;
  endtask

  // append one predicted result at the tail of the owed list
  task automatic owe(input filt_px_t px);
    owed_px.insert(owed_px.size(), px);
  endtask

  function automatic int unsigned span_w();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    return w;
  endfunction

  function automatic int unsigned span_h();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    return h;
  endfunction

  function automatic bit near(input logic [DEPTH_W-1:0] a, input logic [DEPTH_W-1:0] b);
    logic [DEPTH_W:0] gap;
    gap = (a > b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
    return gap < {1'b0, thr_reg};
  endfunction

  // keep the centre pixel when any existing neighbour is close enough
  function automatic logic [DEPTH_W-1:0] speckle_out(input int unsigned c, input int unsigned w,
                                                      input bit has_up, input bit has_down,
                                                      input logic [DEPTH_W-1:0] below);
    logic [DEPTH_W-1:0] v;
    bit                 kept;
    v    = rows_mid[c];
    kept = 1'b0;
    if (has_up && near(v, rows_up[c])) kept = 1'b1;
    if (has_down && near(v, below)) kept = 1'b1;
    if (c > 0 && near(v, rows_up[c-1])) kept = 1'b1;
    if (c + 1 < w && near(v, rows_mid[c+1])) kept = 1'b1;
    return kept ? v : '0;
  endfunction

  task automatic advance(input logic op, input logic [DEPTH_W-1:0] d);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    filt_px_t    px;
    w = span_w();
    h = span_h();
    if (op == OP_PIXEL) begin
      if (drain_left == 0) begin
        if (col_pos >= w) col_pos = 0;
        c = col_pos;
        r = row_pos;
        if (r >= 1) begin
          px.depth     = speckle_out(c, w, r >= 2, 1'b1, d);
          px.frame_end = 1'b0;
          owe(px);
        end
        rows_up[c]  = rows_mid[c];
        rows_mid[c] = d;
        if (c + 1 >= w) begin
          col_pos = 0;
          if (r + 1 >= h) begin
            row_pos    = 0;
            drain_left = w;
          end else begin
            row_pos = r + 1;
          end
        end else begin
          col_pos = c + 1;
        end
      end
    end else if (drain_left != 0) begin
      if (drain_left > w) drain_left = w;
      c          = w - drain_left;
      px.depth   = speckle_out(c, w, h >= 2, 1'b0, '0);
      rows_up[c] = rows_mid[c];
      drain_left--;
      px.frame_end = (drain_left == 0);
      owe(px);
    end
  endtask

  always @(posedge clk) begin
    filt_px_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        rows_up[i]  = '0;
        rows_mid[i] = '0;
      end
      col_pos    = 0;
      row_pos    = 0;
      drain_left = 0;
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      thr_reg    = RST_THRESHOLD;
      closed     = 1'b0;
      owed_px.delete();
    end else begin
      // the result side first: a result never stems from the item taken at the same edge
      if (out_tvalid && out_tready) begin
        result_count++;
        if (owed_px.size() == 0) begin
          flag($sformatf("filtered pixel %0d with nothing owed", out_tdata));
        end else begin
          want = owed_px.pop_front();
          if (out_tdata !== want.depth)
            flag($sformatf("depth_out %0d, predicted %0d", out_tdata, want.depth));
          if (out_tlast !== want.frame_end)
            flag($sformatf("frame_end %0b, predicted %0b", out_tlast, want.frame_end));
        end
      end
      if (in_tvalid && in_tready) advance(in_tuser, in_tdata);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata[CFG_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[CFG_W-1:0];
          CFG_THRESHOLD:    thr_reg    = cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (closing && !closed) begin
        closed = 1'b1;
        if (owed_px.size() != 0)
          flag($sformatf("%0d filtered pixels never arrived", owed_px.size()));
      end
    end
    waiting  <= owed_px.size();
    draining <= (drain_left != 0);
  end

endmodule

@@ tb/sv/tb_depth_speckle_filter_core.sv @@
// top of the depth speckle filter testbench: clock, reset, stimulus, back-pressure and verdict
module tb_depth_speckle_filter_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dsf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1150;
  // cycles left for the pipeline to settle before a register write or the verdict
  localparam int unsigned SETTLE       = 16;
  // generous ceiling on the whole run, well above the slowest legal run
  localparam int unsigned LIMIT        = 1_500_000;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata   = '0;    // [15:0] depth_in
  logic              in_tuser   = 1'b0;  // [0] operation
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;          // [15:0] depth_out
  logic              out_tlast;          // frame_end
  logic              cfg_wr_en  = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [15:0]       cfg_wdata  = '0;
  logic              closing    = 1'b0;

  int unsigned       chk_fails;
  int unsigned       chk_waiting;
  int unsigned       chk_results;
  logic              chk_draining;

  // stimulus bookkeeping
  int unsigned       useful_items  = 0;
  int unsigned       ignored_items = 0;
  int unsigned       cfg_writes    = 0;
  int unsigned       in_calm       = 0;
  // result side back-pressure state
  int unsigned       out_calm      = 0;
  int unsigned       out_stall     = 0;
  logic              out_taken     = 1'b0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  depth_speckle_filter_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  dsf_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .closing      (closing),
    .fail_count   (chk_fails),
    .waiting      (chk_waiting),
    .result_count (chk_results),
    .draining     (chk_draining)
  );

  // result side: after every transaction drop tready or not at random,
  // with occasional calm stretches where it never drops
  always @(posedge clk) out_taken <= out_tvalid && out_tready;

  always @(negedge clk) begin
    if (out_taken) begin
      if (out_calm != 0) begin
        out_calm--;
        out_stall = 0;
      end else begin
        if ($urandom_range(0, 19) == 0) out_calm = $urandom_range(20, 80);
        out_stall = $urandom_range(0, 10);
      end
      if (out_stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        out_stall--;
      end
    end else if (!out_tready) begin
      if (out_stall == 0) out_tready <= 1'b1;
      else out_stall--;
    end
  end

  // one input transaction; called and returning at a falling edge, tvalid is left high
  // so that a following item with no gap keeps the stream busy
  task automatic send_item(input logic op, input logic [15:0] d, input bit counted);
    int unsigned gap;
    if (in_calm != 0) begin
      in_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 24) == 0) in_calm = $urandom_range(20, 80);
      gap = $urandom_range(0, 10);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (counted) useful_items++;
    else ignored_items++;
  endtask

  // stop the stream and let every owed result and any silent work drain out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (chk_waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // writes all three registers on back-to-back cycles; only called when idle
  task automatic set_config(input int unsigned w_raw, input int unsigned h_raw,
                            input logic [15:0] thr);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= 16'(w_raw);
    @(negedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= 16'(h_raw);
    @(negedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes += 3;
  endtask

  function automatic logic [15:0] pick_thr();
    int unsigned k;
    k = $urandom_range(0, 15);
    case (k)
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  // depths cluster around a per-frame base so some pixels are kept and some isolated
  function automatic logic [15:0] pick_depth(input logic [15:0] base, input logic [15:0] jit);
    int unsigned k;
    k = $urandom_range(0, 19);
    case (k)
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return base + (16'($urandom) & jit);
    endcase
  endfunction

  // mid-frame or mid-drain change while idle: sizes only shrink, so every store entry
  // the block reads afterwards has been written in this frame
  task automatic shrink_mid(inout int unsigned fw, inout int unsigned fh);
    wait_idle();
    fw = $urandom_range(1, fw);
    fh = $urandom_range(1, fh);
    set_config(fw, fh, pick_thr());
  endtask

  // one frame: pixels until the block starts draining, then drain ticks until done;
  // brk 1 shrinks the frame after some pixels, brk 2 during the drain
  task automatic run_frame(input int unsigned w_raw, input int unsigned h_raw,
                           input logic [15:0] thr, input int unsigned brk);
    int unsigned fw;
    int unsigned fh;
    int unsigned brk_at;
    int unsigned done;
    logic [15:0] base;
    logic [15:0] jit;
    fw   = (w_raw == 0) ? 1 : ((w_raw > WIDTH_CAP) ? WIDTH_CAP : w_raw);
    fh   = (h_raw == 0) ? 1 : ((h_raw > HEIGHT_CAP) ? HEIGHT_CAP : h_raw);
    base = 16'($urandom);
    jit  = (16'd1 << $urandom_range(1, 10)) - 16'd1;
    wait_idle();
    set_config(w_raw, h_raw, thr);
    brk_at = $urandom_range(1, (brk == 2) ? fw : fw * fh);
    done   = 0;
    while (!chk_draining) begin
      if ($urandom_range(0, 15) == 0) begin
        // drain tick with nothing pending, ignored
        send_item(OP_DRAIN, 16'($urandom), 1'b0);
      end else begin
        send_item(OP_PIXEL, pick_depth(base, jit), 1'b1);
        done++;
        if (brk == 1 && done == brk_at) shrink_mid(fw, fh);
      end
    end
    done = 0;
    while (chk_draining) begin
      if ($urandom_range(0, 7) == 0) begin
        // pixel while the last row drains, ignored
        send_item(OP_PIXEL, 16'($urandom), 1'b0);
      end else begin
        send_item(OP_DRAIN, 16'($urandom), 1'b1);
        done++;
        if (brk == 2 && done == brk_at) shrink_mid(fw, fh);
      end
    end
  endtask

  // watchdog
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("depth_speckle_filter_core: mismatch");
    $finish;
  end

  initial begin
    int unsigned start_items;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned k;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    // drain tick straight after reset, nothing pending
    send_item(OP_DRAIN, 16'hFFFF, 1'b0);

    // zero sizes act as one: a single-pixel frame has no neighbours
    wait_idle();
    set_config(0, 0, 16'd50);
    send_item(OP_PIXEL, 16'hFFFF, 1'b1);
    send_item(OP_PIXEL, 16'h0000, 1'b0);   // ignored, the drain is pending
    send_item(OP_DRAIN, 16'h0000, 1'b1);

    // zero threshold: even equal neighbours do not count
    wait_idle();
    set_config(2, 2, 16'd0);
    repeat (4) send_item(OP_PIXEL, 16'd1000, 1'b1);
    repeat (2) send_item(OP_DRAIN, 16'd0, 1'b1);

    // full-scale checkerboard against the largest threshold
    wait_idle();
    set_config(3, 2, 16'hFFFF);
    send_item(OP_PIXEL, 16'h0000, 1'b1);
    send_item(OP_PIXEL, 16'hFFFF, 1'b1);
    send_item(OP_PIXEL, 16'h0000, 1'b1);
    send_item(OP_PIXEL, 16'hFFFF, 1'b1);
    send_item(OP_PIXEL, 16'h0000, 1'b1);
    send_item(OP_PIXEL, 16'hFFFF, 1'b1);
    repeat (3) send_item(OP_DRAIN, 16'd0, 1'b1);

    // one-column frame: only up and down neighbours exist
    wait_idle();
    set_config(1, 2, 16'd1);
    repeat (2) send_item(OP_PIXEL, 16'd7, 1'b1);
    send_item(OP_DRAIN, 16'd0, 1'b1);

    // --- random frames, mostly small, some cut short by a shrink ---
    start_items = useful_items;
    while (useful_items - start_items < RANDOM_ITEMS) begin
      w_raw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
      h_raw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 39) == 0) w_raw = $urandom_range(13, 64);
      k = $urandom_range(0, 5);
      run_frame(w_raw, h_raw, pick_thr(), (k < 4) ? 0 : k - 3);
    end

    // --- oversized registers saturate: a burst under the clamped size, then a small
    //     frame closes it with the stale column restarting at zero ---
    wait_idle();
    set_config(13'h1FFF, 13'h1FFF, 16'd40);
    repeat (40) send_item(OP_PIXEL, pick_depth(16'd3000, 16'd31), 1'b1);
    run_frame(5, 3, 16'd40, 0);

    // one-column burst: every pixel starts a row, rows far past the old height emit
    wait_idle();
    set_config(1, 13'h1FFF, 16'd40);
    repeat (40) send_item(OP_PIXEL, pick_depth(16'd3000, 16'd31), 1'b1);
    run_frame(1, 3, 16'd40, 0);

    // everything owed must arrive, then nothing more
    wait_idle();
    closing <= 1'b1;
    repeat (2) @(negedge clk);

    $display("covered %0d pixel and drain transactions, %0d ignored ones, %0d register writes",
             useful_items, ignored_items, cfg_writes);
    $display("compared %0d filtered pixels over frames up to 64x8 and bursts at clamped sizes",
             chk_results);
    if (chk_fails == 0) begin
      $display("depth_speckle_filter_core: match");
    end else begin
      $display("depth_speckle_filter_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dsf_pkg.sv
rtl/core/dsf_front.sv
rtl/core/dsf_cmd_fifo.sv
rtl/core/dsf_back.sv
rtl/core/depth_speckle_filter_core.sv
rtl/core/dsf_checker.sv
tb/sv/dsf_checker.sv
tb/sv/tb_depth_speckle_filter_core.sv
